[src/jse_pkg.sv]
// Types, character codes and helpers shared by the JSON string escaper.
// No dependencies; the front end, queue, back end and top level refer to this package.
`timescale 1ns / 1ps

package jse_pkg;

	// Body kinds: what the escaper emits for the character itself
	localparam logic [1:0] KIND_NONE  = 2'd0; // empty string, no body
	localparam logic [1:0] KIND_PLAIN = 2'd1; // unit passes unchanged
	localparam logic [1:0] KIND_PAIR  = 2'd2; // backslash + one character
	localparam logic [1:0] KIND_HEX   = 2'd3; // \u00XX

	// Character codes
	localparam logic [15:0] CH_QUOTE  = 16'h0022;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_ZERO   = 16'h0030;
	localparam logic [15:0] CH_LC_A   = 16'h0061;
	localparam logic [15:0] CH_LC_B   = 16'h0062;
	localparam logic [15:0] CH_LC_F   = 16'h0066;
	localparam logic [15:0] CH_LC_N   = 16'h006E;
	localparam logic [15:0] CH_LC_R   = 16'h0072;
	localparam logic [15:0] CH_LC_T   = 16'h0074;
	localparam logic [15:0] CH_LC_U   = 16'h0075;

	// Control characters with a short escape
	localparam logic [15:0] CC_BS = 16'h0008;
	localparam logic [15:0] CC_HT = 16'h0009;
	localparam logic [15:0] CC_LF = 16'h000A;
	localparam logic [15:0] CC_FF = 16'h000C;
	localparam logic [15:0] CC_CR = 16'h000D;

	// Units below this value are control characters
	localparam logic [15:0] CTRL_LIMIT = 16'h0020;

	// One classified item: how to expand it into output units
	typedef struct packed {
		logic        open;     // opening quote first
		logic [1:0]  kind;     // body kind
		logic [15:0] body;     // character or escape letter
		logic        close;    // closing quote last
		logic [2:0]  last_idx; // index of the run's final unit
	} desc_t;

	// Lowercase hex digit
	function automatic logic [15:0] hex_digit(input logic [3:0] nib);
		logic [15:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {12'd0, nib};
		end else begin
			r = CH_LC_A + {12'd0, nib - 4'd10};
		end
		return r;
	endfunction

endpackage

[src/jse_in_if.sv]
// Input channel of the JSON string escaper: one code unit per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface jse_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        first_unit;
	logic        last_unit;
	logic        empty_string;

	modport source(output valid, output code_unit, output first_unit,
		output last_unit, output empty_string, input ready);
	modport sink(input valid, input code_unit, input first_unit,
		input last_unit, input empty_string, output ready);
endinterface

[src/jse_out_if.sv]
// Output channel of the JSON string escaper: one quoted text unit per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface jse_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_unit;
	logic        string_done;
	logic        run_last;

	modport source(output valid, output out_unit, output string_done,
		output run_last, input ready);
	modport sink(input valid, input out_unit, input string_done,
		input run_last, output ready);
endinterface

[src/jse_front.sv]
// Front end: accepts input beats and classifies each into a run descriptor.
// Depends on jse_pkg and jse_in_if.
`timescale 1ns / 1ps

module jse_front (
	jse_in_if.sink         text,
	input  logic           full,
	output logic           push,
	output jse_pkg::desc_t desc
);

	logic [15:0] c;
	logic [3:0]  body_len;
	logic [3:0]  run_len;

	assign c          = text.code_unit;
	assign text.ready = !full;
	assign push       = text.valid && !full;

	// Classify the unit
	always_comb begin
		desc.open  = text.first_unit;
		desc.close = text.last_unit;
		desc.body  = c;
		desc.kind  = jse_pkg::KIND_PLAIN;
		body_len   = 4'd1;
		if (text.empty_string) begin
			desc.open  = 1'b1;
			desc.close = 1'b1;
			desc.kind  = jse_pkg::KIND_NONE;
			body_len   = 4'd0;
		end else if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
			desc.kind = jse_pkg::KIND_PAIR;
			body_len  = 4'd2;
		end else if (c == jse_pkg::CC_BS) begin
			desc.kind = jse_pkg::KIND_PAIR;
			desc.body = jse_pkg::CH_LC_B;
			body_len  = 4'd2;
		end else if (c == jse_pkg::CC_FF) begin
			desc.kind = jse_pkg::KIND_PAIR;
			desc.body = jse_pkg::CH_LC_F;
			body_len  = 4'd2;
		end else if (c == jse_pkg::CC_LF) begin
			desc.kind = jse_pkg::KIND_PAIR;
			desc.body = jse_pkg::CH_LC_N;
			body_len  = 4'd2;
		end else if (c == jse_pkg::CC_CR) begin
			desc.kind = jse_pkg::KIND_PAIR;
			desc.body = jse_pkg::CH_LC_R;
			body_len  = 4'd2;
		end else if (c == jse_pkg::CC_HT) begin
			desc.kind = jse_pkg::KIND_PAIR;
			desc.body = jse_pkg::CH_LC_T;
			body_len  = 4'd2;
		end else if (c < jse_pkg::CTRL_LIMIT) begin
			desc.kind = jse_pkg::KIND_HEX;
			body_len  = 4'd6;
		end

		// Run length is 1..8 units, stored as its last index
		run_len       = body_len + {3'd0, desc.open} + {3'd0, desc.close};
		desc.last_idx = 3'(run_len - 4'd1);
	end

endmodule

[src/jse_queue.sv]
// Small descriptor queue between front end and back end.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t wr_desc,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output jse_pkg::desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

[src/jse_back.sv]
// Back end: expands the head descriptor into output units, one per beat.
// Depends on jse_pkg and jse_out_if.
`timescale 1ns / 1ps

module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  jse_pkg::desc_t head,
	output logic           pop,
	jse_out_if.source      quoted
);

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [15:0] unit_q;
	logic        done_q;
	logic        last_q;

	logic        load;
	logic        at_end;
	logic [2:0]  bp;
	logic [15:0] unit;

	assign load   = head_valid && (!valid_q || quoted.ready);
	assign at_end = idx_q == head.last_idx;
	assign pop    = load && at_end;
	assign bp     = idx_q - {2'd0, head.open};

	// Unit at the current position of the run
	always_comb begin
		unit = head.body;
		if (head.open && idx_q == 3'd0) begin
			unit = jse_pkg::CH_QUOTE;
		end else if (head.close && at_end) begin
			unit = jse_pkg::CH_QUOTE;
		end else begin
			case (head.kind)
				jse_pkg::KIND_PAIR: begin
					unit = (bp == 3'd0) ? jse_pkg::CH_BSLASH : head.body;
				end
				jse_pkg::KIND_HEX: begin
					case (bp)
						3'd0:    unit = jse_pkg::CH_BSLASH;
						3'd1:    unit = jse_pkg::CH_LC_U;
						3'd2:    unit = jse_pkg::CH_ZERO;
						3'd3:    unit = jse_pkg::CH_ZERO;
						3'd4:    unit = jse_pkg::hex_digit(head.body[7:4]);
						default: unit = jse_pkg::hex_digit(head.body[3:0]);
					endcase
				end
				default: unit = head.body;
			endcase
		end
	end

	// Run index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (quoted.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= unit;
			done_q <= head.close && at_end;
			last_q <= at_end;
		end
	end

	assign quoted.valid       = valid_q;
	assign quoted.out_unit    = unit_q;
	assign quoted.string_done = done_q;
	assign quoted.run_last    = last_q;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.last_idx) else $error("run index past run end");
	a_mid_run_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> head_valid) else $error("head left mid-run");
	a_done_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && done_q |-> unit_q == jse_pkg::CH_QUOTE && last_q)
		else $error("string end not on final closing quote");

endmodule

[src/json_string_escaper.sv]
// Top level of the JSON string escaper: front end, descriptor queue, back end.
// Depends on jse_pkg, jse_in_if, jse_out_if, jse_front, jse_queue, jse_back.
`timescale 1ns / 1ps

// The block takes one 16-bit code unit per beat on text and emits its
// JSON-quoted form on quoted, one unit per beat. A beat is taken in any cycle
// in which the descriptor queue (QUEUE_DEPTH entries) has room, independent of
// the output side; the back end then expands each item into one output unit
// for a plain unit, two for a two-character escape or six for a \u00XX escape,
// plus one for each quote it carries (at most 8 units). Sustained rate is set
// by that output sequencer: one item per cycle for plain text while quoted is
// ready. An accepted beat is written into the queue, then loaded into the
// output register.
module json_string_escaper #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	jse_in_if.sink     text,
	jse_out_if.source  quoted
);

	logic           push;
	logic           pop;
	logic           full;
	logic           head_valid;
	jse_pkg::desc_t wr_desc;
	jse_pkg::desc_t head;

	jse_front u_front (
		.text (text),
		.full (full),
		.push (push),
		.desc (wr_desc)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_desc    (wr_desc),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.quoted     (quoted)
	);

endmodule
